FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ESA_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("esa assertion failed");

// When cond holds, expr holds in the next cycle.
`define ESA_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("esa assertion failed");

`endif

FILE: rtl/esa_pkg.sv
// ----------------------------------------------------------------------------
// esa_pkg
// Beat types and shared constants for the exchange sort block.
// ----------------------------------------------------------------------------
package esa_pkg;

	localparam int DATA_W = 32;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     is_last;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     end_of_set;
		logic                     overflowed;
	} out_item_t;

	// emit request from sequencer to output stage
	typedef struct packed {
		logic valid;
		logic last;
		logic ovf;
	} emit_t;

endpackage

FILE: rtl/exchange_sort_ascending.sv
// ----------------------------------------------------------------------------
// exchange_sort_ascending
// Collects a set of signed words, sorts ascending, streams them back out.
// ----------------------------------------------------------------------------
// Input channel: a beat (item.value, item.is_last) is taken on a rising edge
// with start high and busy low. Beats are taken back to back, one per cycle,
// while loading; is_last closes the set (that beat is part of it).
// Beats past MAX_ITEMS are dropped, and every result of that set then has
// overflowed set.
// Sort: one comparator and one single-port-read store. The outer element is
// kept in a register and compared against each later entry, one per cycle;
// the sort's length is set by that compare loop and the store's one read port.
// Output channel: the n results come out back to back, each held on result
// for one cycle with strobe high; end_of_set marks the largest.
// The receiver cannot stall: results are not held back.
// busy is high from the is_last beat until the cycle that carries the last
// result; the first beat of the next set can be taken in that cycle.
// Reset: empty set, no overflow, idle and ready. Store contents undefined.
// ----------------------------------------------------------------------------
module exchange_sort_ascending
	import esa_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_item_t  item,
	output logic      busy,
	output logic      strobe,
	output out_item_t result
);

	`include "assert_macros.svh"

	localparam int IW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic              mem_we;
	logic [IW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [IW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;
	emit_t             emit;

	// output stage: flags line up with the registered store read
	logic strobe_s1;
	logic end_s1;
	logic ovf_s1;

	esa_ctrl #(
		.MAX_ITEMS (MAX_ITEMS),
		.IW        (IW),
		.CW        (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.emit      (emit)
	);

	esa_mem #(
		.DEPTH (MAX_ITEMS),
		.AW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		end_s1 <= emit.last;
		ovf_s1 <= emit.ovf;
	end

	assign strobe              = strobe_s1;
	assign result.sorted_value = $signed(mem_rdata);
	assign result.end_of_set   = end_s1;
	assign result.overflowed   = ovf_s1;

	// a set ends with a gap: no result directly after end_of_set
	`ESA_ASSERT_NEXT(a_gap_after_end, strobe && result.end_of_set, !strobe)
	// results are only issued while the sequencer is busy or just finishing
	`ESA_ASSERT_NEXT(a_emit_busy, emit.valid && !emit.last, busy)

endmodule

FILE: rtl/esa_mem.sv
// ----------------------------------------------------------------------------
// esa_mem
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module esa_mem
	import esa_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/esa_ctrl.sv
// ----------------------------------------------------------------------------
// esa_ctrl
// Sequencer: loads beats, runs the exchange sort with one comparator, then
// walks the store out in order.
// ----------------------------------------------------------------------------
module esa_ctrl
	import esa_pkg::*;
#(
	parameter int MAX_ITEMS = 64,
	parameter int IW        = 6,
	parameter int CW        = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  in_item_t          item,
	output logic              busy,
	output logic              mem_we,
	output logic [IW-1:0]     mem_waddr,
	output logic [DATA_W-1:0] mem_wdata,
	output logic [IW-1:0]     mem_raddr,
	input  logic [DATA_W-1:0] mem_rdata,
	output emit_t             emit
);

	`include "assert_macros.svh"

	typedef enum logic [2:0] {
		S_LOAD,
		S_RDI,
		S_LDI,
		S_CMP,
		S_WBI,
		S_OUT
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic              drop_q;
	logic              ovf_q;
	logic [IW-1:0]     last_q;
	logic [IW-1:0]     i_q;
	logic [IW-1:0]     k_q;
	logic [IW-1:0]     j_q;
	logic [DATA_W-1:0] cur_q;

	logic          has_room;
	logic [CW-1:0] n_fin;
	logic          gt;

	assign has_room = count_q < CW'(MAX_ITEMS);
	assign n_fin    = has_room ? count_q + CW'(1) : count_q;
	assign gt       = $signed(cur_q) > $signed(mem_rdata);
	assign busy     = state_q != S_LOAD;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = i_q;
		mem_wdata = cur_q;
		mem_raddr = i_q;
		emit      = '0;
		case (state_q)
			S_LOAD: begin
				if (start && has_room) begin
					mem_we    = 1'b1;
					mem_waddr = count_q[IW-1:0];
					mem_wdata = item.value;
				end
			end
			S_RDI: mem_raddr = i_q;
			S_LDI: mem_raddr = k_q;
			S_CMP: begin
				if (gt) begin
					mem_we    = 1'b1;
					mem_waddr = k_q;
				end
				if (k_q != last_q) begin
					mem_raddr = k_q + IW'(1);
				end
			end
			S_WBI: begin
				mem_we    = 1'b1;
				mem_raddr = i_q + IW'(1);
			end
			S_OUT: begin
				mem_raddr  = j_q;
				emit.valid = 1'b1;
				emit.last  = j_q == last_q;
				emit.ovf   = ovf_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			drop_q  <= 1'b0;
			ovf_q   <= 1'b0;
			last_q  <= '0;
			i_q     <= '0;
			k_q     <= '0;
			j_q     <= '0;
			cur_q   <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (start) begin
						if (has_room) begin
							count_q <= count_q + CW'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (item.is_last) begin
							last_q  <= IW'(n_fin - CW'(1));
							ovf_q   <= drop_q | ~has_room;
							i_q     <= '0;
							j_q     <= '0;
							state_q <= (n_fin == CW'(1)) ? S_OUT : S_RDI;
						end
					end
				end
				S_RDI: begin
					k_q     <= i_q + IW'(1);
					state_q <= S_LDI;
				end
				S_LDI: begin
					cur_q   <= mem_rdata;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (gt) begin
						cur_q <= mem_rdata;
					end
					if (k_q == last_q) begin
						state_q <= S_WBI;
					end else begin
						k_q <= k_q + IW'(1);
					end
				end
				S_WBI: begin
					i_q <= i_q + IW'(1);
					k_q <= i_q + IW'(2);
					if (i_q + IW'(1) == last_q) begin
						j_q     <= '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_LDI;
					end
				end
				S_OUT: begin
					j_q <= j_q + IW'(1);
					if (j_q == last_q) begin
						count_q <= '0;
						drop_q  <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// swap write never collides with the read issued in the same cycle
	`ESA_ASSERT(a_no_rw_clash, (state_q == S_CMP && mem_we) |-> (mem_waddr != mem_raddr))
	// inner index always runs ahead of the outer index
	`ESA_ASSERT(a_k_ahead, (state_q == S_CMP) |-> (k_q > i_q && k_q <= last_q))
	// fill count never passes capacity
	`ESA_ASSERT(a_count_cap, count_q <= CW'(MAX_ITEMS))

endmodule
